@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_AT(label, clk, rstn, !(cond), msg)

`endif

@@ rtl/rit_pkg.sv @@
`timescale 1ns / 1ps

package rit_pkg;

    // Field and register widths
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 5;
    localparam int ALPHA_N     = 16;
    localparam int ALPHA_IDX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // Default sizes
    localparam int DEF_MAX_RADIX  = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;

    // Special characters
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Register reset values: decimal alphabet "0123456789"
    localparam logic [RADIX_W-1:0]    RADIX_RESET       = 5'd10;
    localparam logic [CFG_DATA_W-1:0] DIGITS_LOW_RESET  = 64'd3978425819141910832;
    localparam logic [CFG_DATA_W-1:0] DIGITS_HIGH_RESET = 64'd14648;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX       = 2'd0,
        REG_DIGITS_LOW  = 2'd1,
        REG_DIGITS_HIGH = 2'd2
    } cfg_reg_t;

    // Live conversion settings handed to the back end
    typedef struct packed {
        logic [RADIX_W-1:0]              radix;
        logic [ALPHA_N-1:0][CHAR_W-1:0] alphabet;
    } cfg_t;

endpackage

@@ rtl/rit_front.sv @@
`timescale 1ns / 1ps

module rit_front
    import rit_pkg::*;
#(
    parameter int MAX_RADIX  = DEF_MAX_RADIX,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  q_push,
    output logic [VALUE_BITS:0]   q_data,
    input  logic                  q_full,
    output cfg_t                  cfg
);

    logic [RADIX_W-1:0]              radix_reg;
    logic [ALPHA_N-1:0][CHAR_W-1:0] alphabet_reg;
    logic                            alpha_ok_reg;
    logic                            alpha_ok_next;
    logic                            hold_valid_reg;
    logic                            hold_neg_reg;
    logic [VALUE_BITS-1:0]           hold_mag_reg;
    logic                            accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RADIX_RESET;
            alphabet_reg <= {DIGITS_HIGH_RESET, DIGITS_LOW_RESET};
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_RADIX:       radix_reg <= cfg_wr_data[RADIX_W-1:0];
                REG_DIGITS_LOW:  alphabet_reg[ALPHA_N/2-1:0] <= cfg_wr_data;
                REG_DIGITS_HIGH: alphabet_reg[ALPHA_N-1:ALPHA_N/2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Validate the used part of the alphabet
    always_comb begin
        alpha_ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ALPHA_N; i++) begin
            if (RADIX_W'(i) < radix_reg) begin
                if (alphabet_reg[i] == CHAR_NUL || alphabet_reg[i] == CHAR_PLUS ||
                    alphabet_reg[i] == CHAR_MINUS) begin
                    alpha_ok_next = 1'b0;
                end
                for (int j = i + 1; j < ALPHA_N; j++) begin
                    if (RADIX_W'(j) < radix_reg && alphabet_reg[j] == alphabet_reg[i]) begin
                        alpha_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_ok_reg <= 1'b1;
        end else begin
            alpha_ok_reg <= alpha_ok_next;
        end
    end

    // Take one beat, split into sign and magnitude
    assign s_tready = !hold_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (hold_valid_reg && (!alpha_ok_reg || !q_full)) begin
            // drop on a bad alphabet, else hand over to the queue
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_neg_reg <= s_value[VALUE_BITS-1];
            hold_mag_reg <= s_value[VALUE_BITS-1] ? (~s_value + VALUE_BITS'(1)) : s_value;
        end
    end

    assign q_push       = hold_valid_reg && alpha_ok_reg && !q_full;
    assign q_data       = {hold_neg_reg, hold_mag_reg};
    assign cfg.radix    = radix_reg;
    assign cfg.alphabet = alphabet_reg;

endmodule

@@ rtl/rit_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rit_queue
    import rit_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `ASSERT_NEVER(a_q_overflow, aclk, aresetn, push && full, "queue push while full")
    `ASSERT_NEVER(a_q_underflow, aclk, aresetn, pop && empty, "queue pop while empty")
    `ASSERT_AT(a_q_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

@@ rtl/rit_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rit_back
    import rit_pkg::*;
#(
    parameter int MAX_RADIX  = DEF_MAX_RADIX,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  logic [VALUE_BITS:0] q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_char,
    output logic                m_last
);

    localparam int ND = VALUE_BITS;
    localparam int DW = $clog2(MAX_RADIX);
    localparam int LW = $clog2(ND + 1);
    localparam int PW = $clog2(ND);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [ND-1:0]            mag_reg;
    logic                     neg_reg;
    logic [ND-1:0][DW-1:0]    digits_reg;
    logic [ND-1:0][DW-1:0]    digits_next;
    logic [LW-1:0]            len_reg;
    logic [LW-1:0]            len_next;
    logic [PW-1:0]            ptr_reg;
    logic [PW-1:0]            bit_cnt_reg;
    logic                     out_valid_reg;
    logic [CHAR_W-1:0]        out_char_reg;
    logic                     out_last_reg;

    logic [RADIX_W-1:0]       dbl [ND];
    logic [ND-1:0]            gen;
    logic [ND-1:0]            gen_prop;
    logic [ND:0]              sum;
    logic [ND:0]              carry;
    logic                     out_free;
    logic                     load;
    logic [CHAR_W-1:0]        emit_char;
    logic                     ptr_ok;

    // Shift one magnitude bit into the digit row; the digit carries resolve as one add
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            dbl[k]      = RADIX_W'({digits_reg[k], 1'b0});
            gen[k]      = (dbl[k] >= cfg.radix);
            gen_prop[k] = gen[k] || ((dbl[k] + RADIX_W'(1)) == cfg.radix);
        end
        sum = (ND+1)'(gen) + (ND+1)'(gen_prop) + (ND+1)'(mag_reg[ND-1]);
        for (int k = 0; k < ND; k++) begin
            carry[k] = sum[k] ^ gen[k] ^ gen_prop[k];
        end
        carry[ND] = sum[ND];
        for (int k = 0; k < ND; k++) begin
            digits_next[k] = DW'((dbl[k] | RADIX_W'(carry[k])) -
                                 (carry[k+1] ? cfg.radix : RADIX_W'(0)));
        end
        len_next = len_reg + LW'(carry[len_reg]);
    end

    // Map the current digit through the alphabet
    assign emit_char = cfg.alphabet[ALPHA_IDX_W'(digits_reg[ptr_reg])];

    assign out_free = !out_valid_reg || m_tready;
    assign load     = out_free && (state_reg == ST_SIGN || state_reg == ST_EMIT);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && !load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        mag_reg     <= q_data[ND-1:0];
                        neg_reg     <= q_data[ND];
                        digits_reg  <= '0;
                        len_reg     <= LW'(1);
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    mag_reg     <= {mag_reg[ND-2:0], 1'b0};
                    digits_reg  <= digits_next;
                    len_reg     <= len_next;
                    bit_cnt_reg <= bit_cnt_reg + PW'(1);
                    if (bit_cnt_reg == PW'(ND - 1)) begin
                        ptr_reg   <= PW'(len_next - LW'(1));
                        state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= CHAR_MINUS;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= emit_char;
                        out_last_reg  <= (ptr_reg == '0);
                        if (ptr_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ptr_reg <= ptr_reg - PW'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_char   = out_char_reg;
    assign m_last   = out_last_reg;

    // Digit pointer stays within the converted digits while emitting
    assign ptr_ok = (state_reg != ST_EMIT) || (LW'(ptr_reg) < len_reg);

    `ASSERT_AT(a_ptr_in_len, aclk, aresetn, ptr_ok, "digit pointer beyond digit count")
    `ASSERT_AT(a_pop_starts_conv, aclk, aresetn, q_pop |=> (state_reg == ST_CONV), "no conversion")
    `ASSERT_NEVER(a_out_overrun, aclk, aresetn, load && out_valid_reg && !m_tready, "output overrun")

endmodule

@@ rtl/radix_integer_to_text_unit.sv @@
// Each value passes through a bit-serial radix conversion (one input bit per cycle),
// followed by one character per cycle while m_tready is high; the queue lets new values
// be accepted while an earlier one is still being converted.
// Values met with an invalid alphabet are dropped in the cycle after acceptance.
// Reset: aresetn, synchronous, active low; radix 10 with alphabet "0123456789",
// queue empty, no output pending.
`timescale 1ns / 1ps

module radix_integer_to_text_unit
    import rit_pkg::*;
#(
    parameter int MAX_RADIX  = DEF_MAX_RADIX,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]               cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [CHAR_W-1:0]                   m_tdata,   // out_char
    output logic                                m_tlast    // is_last
);

    logic                  q_push;
    logic [VALUE_BITS:0]   q_push_data;
    logic                  q_full;
    logic                  q_pop;
    logic [VALUE_BITS:0]   q_pop_data;
    logic                  q_empty;
    cfg_t                  cfg;

    // Accept, hold settings, classify
    rit_front #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_value      (s_tdata[VALUE_BITS-1:0]),
        .q_push       (q_push),
        .q_data       (q_push_data),
        .q_full       (q_full),
        .cfg          (cfg)
    );

    // Decouple front from back
    rit_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Convert and emit characters
    rit_back #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rit_pkg::*;

    localparam int SETTLE_CYCLES = 90;        // conversion latency plus a full text
    localparam int RANDOM_VALUES = 435;       // values converted under good alphabets
    localparam int RUN_LIMIT_NS  = 40_000_000;

    typedef enum {JOB_VALUE, JOB_WRITE, JOB_SETTLE} job_kind_t;

    typedef struct {
        job_kind_t                kind;
        logic [DEF_VALUE_BITS-1:0] value;
        cfg_reg_t                 index;
        logic [CFG_DATA_W-1:0]    data;
    } job_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    cfg_reg_t                  cfg_wr_index = REG_RADIX;
    logic [CFG_DATA_W-1:0]     cfg_wr_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [DEF_VALUE_BITS-1:0] s_tdata = '0;  // value
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [CHAR_W-1:0]         m_tdata;       // out_char
    logic                      m_tlast;       // is_last

    // Stimulus plan and expected text
    job_t       job_q[$];
    text_beat_t text_q[$];

    // Converter settings as the bench sees them
    logic [RADIX_W-1:0]    radix_now = RADIX_RESET;
    logic [CFG_DATA_W-1:0] digits_lo_now = DIGITS_LOW_RESET;
    logic [CFG_DATA_W-1:0] digits_hi_now = DIGITS_HIGH_RESET;

    int values_sent = 0;
    int values_dropped = 0;
    int chars_seen = 0;
    int writes_done = 0;
    int err_count = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet = 0;
    int tx_steady = 0;
    int rx_steady = 0;

    radix_integer_to_text_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int idle_len(ref int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            steady = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(int unsigned k);
        if (k < 8) return digits_lo_now[8*k +: 8];
        return digits_hi_now[8*(k-8) +: 8];
    endfunction

    // Queue the characters one value turns into under the current alphabet
    function automatic void render_value(logic [DEF_VALUE_BITS-1:0] v);
        logic [CHAR_W-1:0]         rev[DEF_VALUE_BITS];
        logic [DEF_VALUE_BITS-1:0] mag;
        logic [CHAR_W-1:0]         c;
        text_beat_t                beat;
        bit                        ok;
        bit                        neg;
        int                        nd;

        ok = (radix_now >= 2) && (radix_now <= DEF_MAX_RADIX);
        for (int i = 0; ok && i < radix_now; i++) begin
            c = digit_char(i);
            if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) ok = 0;
            for (int j = i + 1; j < radix_now; j++)
                if (digit_char(j) == c) ok = 0;
        end
        if (!ok) begin
            values_dropped++;
            return;
        end

        // Magnitude as unsigned, so the most negative value stays exact
        neg = v[DEF_VALUE_BITS-1];
        mag = neg ? -v : v;
        nd = 0;
        do begin
            rev[nd] = digit_char(int'(mag % radix_now));
            mag = mag / radix_now;
            nd++;
        end while (mag != 0 && nd < DEF_VALUE_BITS);

        if (neg) begin
            beat.ch = CHAR_MINUS;
            beat.last = 1'b0;
            text_q.push_back(beat);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            beat.ch = rev[i];
            beat.last = (i == 0);
            text_q.push_back(beat);
        end
    endfunction

    function automatic void add_value(logic [DEF_VALUE_BITS-1:0] v);
        job_t j;
        j.kind = JOB_VALUE;
        j.value = v;
        j.index = REG_RADIX;
        j.data = '0;
        job_q.push_back(j);
    endfunction

    function automatic void add_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        job_t j;
        j.kind = JOB_WRITE;
        j.value = '0;
        j.index = idx;
        j.data = d;
        job_q.push_back(j);
    endfunction

    function automatic void add_settle();
        job_t j;
        j.kind = JOB_SETTLE;
        j.value = '0;
        j.index = REG_RADIX;
        j.data = '0;
        job_q.push_back(j);
    endfunction

    // Input driver: values, register writes while idle, and drain points
    always @(posedge aclk) begin
        logic nxt_valid;
        logic nxt_wr;
        nxt_valid = 1'b0;
        nxt_wr = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_value(s_tdata);
                values_sent++;
                void'(job_q.pop_front());
                hold_left = idle_len(tx_steady);
            end
            if (!s_tvalid && text_q.size() == 0) quiet++;
            else quiet = 0;

            if (s_tvalid && !s_tready) begin
                nxt_valid = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (job_q.size() > 0) begin
                case (job_q[0].kind)
                    JOB_VALUE: begin
                        nxt_valid = 1'b1;
                        s_tdata <= job_q[0].value;
                    end
                    JOB_WRITE: begin
                        // Write only once the block has gone quiet
                        if (text_q.size() == 0 && quiet >= SETTLE_CYCLES) begin
                            nxt_wr = 1'b1;
                            cfg_wr_index <= job_q[0].index;
                            cfg_wr_data <= job_q[0].data;
                            case (job_q[0].index)
                                REG_RADIX:       radix_now = job_q[0].data[RADIX_W-1:0];
                                REG_DIGITS_LOW:  digits_lo_now = job_q[0].data;
                                REG_DIGITS_HIGH: digits_hi_now = job_q[0].data;
                                default: ;
                            endcase
                            writes_done++;
                            void'(job_q.pop_front());
                        end
                    end
                    default: begin
                        if (text_q.size() == 0) void'(job_q.pop_front());
                    end
                endcase
            end
            s_tvalid <= nxt_valid;
            cfg_wr_en <= nxt_wr;
        end
    end

    // Output monitor: check each character beat, stall at random
    always @(posedge aclk) begin
        text_beat_t want;
        logic       nxt_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (text_q.size() == 0) begin
                    $error("out_char: no character expected, got 0x%02h (is_last %0b)",
                           m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want = text_q.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected 0x%02h, got 0x%02h", want.ch, m_tdata);
                        err_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("is_last: expected %0b, got %0b", want.last, m_tlast);
                        err_count++;
                    end
                end
                stall_left = idle_len(rx_steady);
            end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
                stall_left = idle_len(rx_steady);
            end
            if (stall_left > 0) begin
                nxt_ready = 1'b0;
                stall_left--;
            end else begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    // Plan the stimulus, release reset, then wait for the last character
    initial begin
        logic [CHAR_W-1:0]         alpha[ALPHA_N];
        bit                        taken[256];
        logic [CFG_DATA_W-1:0]     lo;
        logic [CFG_DATA_W-1:0]     hi;
        logic [CFG_DATA_W-1:0]     rdata;
        logic [DEF_VALUE_BITS-1:0] v;
        int                        rdx;
        int                        planned;
        int                        n;
        int                        pick;
        int                        i;
        int                        j;
        bit                        flaw;

        // Reset alphabet, decimal: zero, single digits of both signs, extremes
        add_value(32'd0);
        add_value(32'd1);
        add_value(-32'sd1);
        add_value(32'd9);
        add_value(-32'sd9);
        add_settle();
        add_value(32'd10);
        add_value(32'h7FFF_FFFF);
        add_value(32'h8000_0000);
        add_value(-32'sd1000000000);
        add_value(32'd123456789);

        // Binary with extreme bytes as digits; unused bytes are repeats or NUL
        add_write(REG_RADIX, 64'd2);
        add_write(REG_DIGITS_LOW, 64'hFFFF_FFFF_FFFF_FF01);
        add_write(REG_DIGITS_HIGH, 64'h0);
        add_value(32'h8000_0000);
        add_value(32'hFFFF_FFFF);
        add_value(32'h0);
        add_value(32'h5555_5555);

        // Hexadecimal, lower case
        add_write(REG_RADIX, 64'd16);
        add_write(REG_DIGITS_LOW, DIGITS_LOW_RESET);
        add_write(REG_DIGITS_HIGH, 64'h6665_6463_6261_3938);
        add_value(32'hDEAD_BEEF);
        add_value(32'h7FFF_FFFF);
        add_value(32'h0000_000F);

        // Bad alphabets: values must vanish
        add_write(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE0);
        add_value(32'h1234_5678);
        add_write(REG_RADIX, 64'd1);
        add_value(32'h8765_4321);
        add_write(REG_RADIX, 64'd17);
        add_value(32'hFFFF_FF00);
        add_write(REG_RADIX, 64'd31);
        add_value(32'h0000_0042);
        add_write(REG_RADIX, 64'd16);
        add_write(REG_DIGITS_HIGH, 64'h0065_6463_6261_3938);
        add_value(32'h0000_00FF);
        add_write(REG_RADIX, 64'd10);
        add_write(REG_DIGITS_HIGH, DIGITS_HIGH_RESET);
        add_write(REG_DIGITS_LOW, 64'h3736_3534_2B32_3130);
        add_value(32'd77);
        add_write(REG_DIGITS_LOW, 64'h3736_3534_3332_312D);
        add_value(-32'sd77);
        add_write(REG_DIGITS_LOW, 64'h3036_3534_3332_3130);
        add_value(32'd500);

        // Random alphabets, mostly good, now and then broken
        planned = 0;
        while (planned < RANDOM_VALUES) begin
            rdx = $urandom_range(2, 16);
            taken = '{default: 0};
            for (int k = 0; k < ALPHA_N; k++) begin
                if (k < rdx) begin
                    do pick = $urandom_range(0, 255);
                    while (pick == CHAR_NUL || pick == CHAR_PLUS || pick == CHAR_MINUS ||
                           taken[pick]);
                    taken[pick] = 1;
                    alpha[k] = CHAR_W'(pick);
                end else begin
                    alpha[k] = CHAR_W'($urandom_range(0, 255));
                end
            end
            flaw = ($urandom_range(0, 99) < 15);
            if (flaw) begin
                case ($urandom_range(0, 3))
                    0: rdx = $urandom_range(0, 1);
                    1: rdx = $urandom_range(17, 31);
                    2: begin
                        case ($urandom_range(0, 2))
                            0: alpha[$urandom_range(0, rdx - 1)] = CHAR_NUL;
                            1: alpha[$urandom_range(0, rdx - 1)] = CHAR_PLUS;
                            default: alpha[$urandom_range(0, rdx - 1)] = CHAR_MINUS;
                        endcase
                    end
                    default: begin
                        i = $urandom_range(0, rdx - 1);
                        do j = $urandom_range(0, rdx - 1);
                        while (j == i);
                        alpha[j] = alpha[i];
                    end
                endcase
            end
            for (int k = 0; k < 8; k++) begin
                lo[8*k +: 8] = alpha[k];
                hi[8*k +: 8] = alpha[k + 8];
            end
            rdata = {$urandom, $urandom};
            rdata[RADIX_W-1:0] = rdx[RADIX_W-1:0];
            if ($urandom_range(0, 1)) begin
                add_write(REG_RADIX, rdata);
                add_write(REG_DIGITS_LOW, lo);
                add_write(REG_DIGITS_HIGH, hi);
            end else begin
                add_write(REG_DIGITS_HIGH, hi);
                add_write(REG_DIGITS_LOW, lo);
                add_write(REG_RADIX, rdata);
            end

            if (flaw) begin
                repeat (3) add_value($urandom);
            end else begin
                n = $urandom_range(8, 30);
                if (n > RANDOM_VALUES - planned) n = RANDOM_VALUES - planned;
                for (int k = 0; k < n; k++) begin
                    if (k == n / 2 && $urandom_range(0, 4) == 0) add_settle();
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1, 2, 3: v = $urandom;
                        4, 5, 6: v = $urandom_range(0, rdx * rdx * rdx);
                        7: v = $urandom_range(0, rdx - 1);
                        8: begin
                            case ($urandom_range(0, 3))
                                0: v = 32'h8000_0000;
                                1: v = 32'h7FFF_FFFF;
                                2: v = '1;
                                default: v = '0;
                            endcase
                        end
                        default: v = $urandom >> $urandom_range(0, 31);
                    endcase
                    if (pick >= 4 && pick != 8 && $urandom_range(0, 1)) v = -v;
                    add_value(v);
                    planned++;
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_q.size() != 0 || s_tvalid || text_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d values (%0d dropped under invalid alphabets), %0d characters checked.",
                 values_sent, values_dropped, chars_seen);
        $display("Applied %0d register writes across radices 0 to 31 and random alphabets.",
                 writes_done);
        if (err_count == 0) begin
            $display("** radix_integer_to_text_unit: PASSED **");
        end else begin
            $display("** radix_integer_to_text_unit: FAILED **");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d values sent, %0d characters still expected.",
                 values_sent, text_q.size());
        $display("** radix_integer_to_text_unit: FAILED **");
        $finish;
    end

endmodule
